// ===== hdl/grcwh_pkg.sv =====
// Shared types and constants for the grid ray caster.
package grcwh_pkg;

  localparam int MAP_BITS_DEF   = 6;
  localparam int FAR_LIMIT_DEF  = 4096;

  localparam int RECIP_DIVIDEND = 4096;
  localparam int RECIP_MAX      = 255;
  localparam logic [7:0] FRAC_MASK = 8'hff;
  localparam int CROSS_STEP     = 256;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  localparam logic [1:0] FACE_WEST  = 2'd0;
  localparam logic [1:0] FACE_NORTH = 2'd1;
  localparam logic [1:0] FACE_EAST  = 2'd2;
  localparam logic [1:0] FACE_SOUTH = 2'd3;

  typedef enum logic [2:0] {
    T_IDLE,
    T_MUL,
    T_ERR,
    T_READ,
    T_CHECK,
    T_HEIGHT,
    T_DONE
  } trace_state_t;

  typedef enum logic [1:0] {
    H_IDLE,
    H_DIV,
    H_MUL,
    H_SAT
  } height_state_t;

  typedef struct packed {
    logic       done;
    logic [7:0] height;
  } height_rsp_t;

endpackage

// ===== hdl/grcwh_map.sv =====
// Map cell memory with the post-reset clearing sweep.
module grcwh_map #(
  parameter int MAP_BITS = grcwh_pkg::MAP_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  we,
  input  logic [2*MAP_BITS-1:0] addr,
  input  logic [7:0]            wdata,
  output logic [7:0]            rd_data,
  output logic                  clearing
);

  localparam int AW    = 2 * MAP_BITS;
  localparam int DEPTH = 1 << AW;

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) clearing <= 1'b0;
    end
  end

  // read-first single port; the sweep owns the port until it ends
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'd0;
    end else if (en) begin
      if (we) mem[addr] <= wdata;
      rd_data <= mem[addr];
    end
  end

endmodule

// ===== hdl/grcwh_height.sv =====
// Height: 0 if far, else serial or saturated 1/distance, scaled by the step delta.
module grcwh_height #(
  parameter int FAR_LIMIT = grcwh_pkg::FAR_LIMIT_DEF,
  parameter int RW        = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [7:0]             u,
  input  logic [RW-1:0]          r,
  output grcwh_pkg::height_rsp_t rsp
);

  localparam int RB    = $clog2(FAR_LIMIT);
  localparam int CW    = RB + 8;
  localparam int REMW  = $clog2(grcwh_pkg::RECIP_DIVIDEND + 1);
  localparam int SAT_R = grcwh_pkg::RECIP_DIVIDEND / (grcwh_pkg::RECIP_MAX + 1);

  grcwh_pkg::height_state_t state, state_next;

  logic [7:0]      u_q;
  logic [RB-1:0]   rdiv;
  logic [REMW-1:0] rem;
  logic [7:0]      q;
  logic [2:0]      bit_idx;
  logic [15:0]     prod;
  logic [CW-1:0]   trial;
  logic            far, near;

  assign trial = CW'(rdiv) << bit_idx;
  assign far   = (r >= RW'(FAR_LIMIT));
  assign near  = (r <= RW'(SAT_R));

  always_ff @(posedge clk) begin
    if (rst) state <= grcwh_pkg::H_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      grcwh_pkg::H_IDLE: begin
        if (start && !far) state_next = near ? grcwh_pkg::H_MUL : grcwh_pkg::H_DIV;
      end
      grcwh_pkg::H_DIV: begin
        if (bit_idx == 3'd0) state_next = grcwh_pkg::H_MUL;
      end
      grcwh_pkg::H_MUL: state_next = grcwh_pkg::H_SAT;
      grcwh_pkg::H_SAT: state_next = grcwh_pkg::H_IDLE;
      default:          state_next = grcwh_pkg::H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        grcwh_pkg::H_IDLE: begin
          if (start) begin
            u_q     <= u;
            rdiv    <= r[RB-1:0];
            rem     <= REMW'(grcwh_pkg::RECIP_DIVIDEND);
            bit_idx <= 3'd7;
            q       <= near ? 8'(grcwh_pkg::RECIP_MAX) : 8'd0;
            if (far) begin
              rsp.height <= 8'd0;
              rsp.done   <= 1'b1;
            end
          end
        end
        grcwh_pkg::H_DIV: begin
          // restoring division, one quotient bit per cycle; quotient < 256 here
          if (CW'(rem) >= trial) begin
            rem        <= rem - trial[REMW-1:0];
            q[bit_idx] <= 1'b1;
          end
          bit_idx <= bit_idx - 3'd1;
        end
        grcwh_pkg::H_MUL: prod <= u_q * q;
        grcwh_pkg::H_SAT: begin
          rsp.height <= (prod[15:12] != 4'd0) ? 8'(grcwh_pkg::RECIP_MAX) : prod[11:4];
          rsp.done   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/grcwh_tracer.sv =====
// Ray tracer sequencer: set-up, cell-by-cell walk over the map, result register.
module grcwh_tracer #(
  parameter int MAP_BITS = grcwh_pkg::MAP_BITS_DEF,
  parameter int RW       = MAP_BITS + 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [5:0]             column,
  input  logic [13:0]            pos_x,
  input  logic [13:0]            pos_y,
  input  logic signed [10:0]     dir_x,
  input  logic signed [10:0]     dir_y,
  output logic                   idle,
  output logic                   rd_en,
  output logic [2*MAP_BITS-1:0]  rd_addr,
  input  logic [7:0]             rd_data,
  output logic                   h_start,
  output logic [7:0]             h_u,
  output logic [RW-1:0]          h_r,
  input  grcwh_pkg::height_rsp_t h_rsp,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [5:0]             column_tag,
  output logic [5:0]             hit_x,
  output logic [5:0]             hit_y,
  output logic [7:0]             hit_code,
  output logic [7:0]             wall_height
);

  localparam int MB = MAP_BITS;
  localparam int SW = MAP_BITS + 2;
  localparam logic [SW-1:0] STEP_LIMIT = SW'(2 * (1 << MAP_BITS));

  grcwh_pkg::trace_state_t state, state_next;

  logic [5:0]    tag;
  logic          negx, negy, step_x;
  logic [7:0]    ux, uy, fx, fy;
  logic [MB-1:0] cx, cy, cx_step, cy_step;
  logic [15:0]   prod_a, prod_b;
  logic [7:0]    id;
  logic [RW-1:0] rx, ry;
  logic [SW-1:0] steps;
  logic [MB-1:0] res_x, res_y;
  logic [7:0]    res_code, res_height;
  logic          load_out;

  logic [10:0] magx, magy;
  logic [9:0]  satx, saty;
  logic [13:0] cxs_ext, cys_ext, rx_ext, ry_ext;
  logic [16:0] diff;
  logic [1:0]  face;

  // start-up: direction magnitudes, saturated, and reflected fractions
  assign magx    = dir_x[10] ? (~dir_x + 11'd1) : dir_x;
  assign magy    = dir_y[10] ? (~dir_y + 11'd1) : dir_y;
  assign satx    = magx[10] ? 10'h3ff : magx[9:0];
  assign saty    = magy[10] ? 10'h3ff : magy[9:0];
  assign cxs_ext = {8'd0, pos_x[13:8]};
  assign cys_ext = {8'd0, pos_y[13:8]};

  assign diff    = {1'b0, prod_a} - {1'b0, prod_b};
  assign cx_step = negx ? cx - 1'b1 : cx + 1'b1;
  assign cy_step = negy ? cy - 1'b1 : cy + 1'b1;
  assign face    = step_x ? (negx ? grcwh_pkg::FACE_WEST  : grcwh_pkg::FACE_EAST)
                          : (negy ? grcwh_pkg::FACE_NORTH : grcwh_pkg::FACE_SOUTH);

  assign idle = (state == grcwh_pkg::T_IDLE);
  assign h_u  = step_x ? ux : uy;
  assign h_r  = step_x ? rx : ry;

  always_ff @(posedge clk) begin
    if (rst) state <= grcwh_pkg::T_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = id[7] ? {cy, cx_step} : {cy_step, cx};
    h_start    = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      grcwh_pkg::T_IDLE:  if (start) state_next = grcwh_pkg::T_MUL;
      grcwh_pkg::T_MUL:   state_next = grcwh_pkg::T_ERR;
      grcwh_pkg::T_ERR:   state_next = grcwh_pkg::T_READ;
      grcwh_pkg::T_READ: begin
        if (steps == STEP_LIMIT) begin
          state_next = grcwh_pkg::T_DONE;
        end else begin
          rd_en      = 1'b1;
          state_next = grcwh_pkg::T_CHECK;
        end
      end
      grcwh_pkg::T_CHECK: begin
        if (rd_data != 8'd0) begin
          h_start    = 1'b1;
          state_next = grcwh_pkg::T_HEIGHT;
        end else begin
          state_next = grcwh_pkg::T_READ;
        end
      end
      grcwh_pkg::T_HEIGHT: if (h_rsp.done) state_next = grcwh_pkg::T_DONE;
      grcwh_pkg::T_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = grcwh_pkg::T_IDLE;
        end
      end
      default: state_next = grcwh_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      grcwh_pkg::T_IDLE: begin
        if (start) begin
          tag  <= column;
          negx <= dir_x[10];
          negy <= dir_y[10];
          ux   <= satx[9:2];
          uy   <= saty[9:2];
          fx   <= dir_x[10] ? pos_x[7:0] : pos_x[7:0] ^ grcwh_pkg::FRAC_MASK;
          fy   <= dir_y[10] ? pos_y[7:0] : pos_y[7:0] ^ grcwh_pkg::FRAC_MASK;
          cx   <= cxs_ext[MB-1:0];
          cy   <= cys_ext[MB-1:0];
        end
      end
      grcwh_pkg::T_MUL: begin
        prod_a <= fx * uy;
        prod_b <= fy * ux;
      end
      grcwh_pkg::T_ERR: begin
        id    <= diff[15:8];
        rx    <= RW'(fx);
        ry    <= RW'(fy);
        steps <= '0;
      end
      grcwh_pkg::T_READ: begin
        if (steps == STEP_LIMIT) begin
          // miss
          res_x      <= '0;
          res_y      <= '0;
          res_code   <= 8'd0;
          res_height <= 8'd0;
        end else begin
          step_x <= id[7];
          steps  <= steps + 1'b1;
          if (id[7]) cx <= cx_step;
          else       cy <= cy_step;
        end
      end
      grcwh_pkg::T_CHECK: begin
        if (rd_data != 8'd0) begin
          res_x    <= cx;
          res_y    <= cy;
          res_code <= rd_data | {6'd0, face};
        end else if (step_x) begin
          rx <= rx + RW'(grcwh_pkg::CROSS_STEP);
          id <= id + uy;
        end else begin
          ry <= ry + RW'(grcwh_pkg::CROSS_STEP);
          id <= id - ux;
        end
      end
      grcwh_pkg::T_HEIGHT: if (h_rsp.done) res_height <= h_rsp.height;
      default: ;
    endcase
  end

  assign rx_ext = 14'(res_x);
  assign ry_ext = 14'(res_y);

  // result register: the next request may enter while this one waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      column_tag  <= tag;
      hit_x       <= rx_ext[5:0];
      hit_y       <= ry_ext[5:0];
      hit_code    <= res_code;
      wall_height <= res_height;
    end
  end

endmodule

// ===== hdl/grid_ray_cast_wall_height.sv =====
// Write request: no result. Cast request: set-up, one registered map read per cell crossing,
// then the height: zero past the far limit or for a miss after n = 2*side crossings, the
// saturated reciprocal when near, else an 8-bit serial reciprocal; the next request is
// taken in the cycle the result appears.
// One request is in work at a time; a result waiting to be taken does not stop the next.
// Reset: synchronous; afterwards a sweep clears the map, one cell a cycle, over
// 2^(2*MAP_BITS) cells (4096 by default), with in_ready low.
module grid_ray_cast_wall_height #(
  parameter int MAP_BITS  = grcwh_pkg::MAP_BITS_DEF,
  parameter int FAR_LIMIT = grcwh_pkg::FAR_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [5:0]         cell_x,
  input  logic [5:0]         cell_y,
  input  logic [7:0]         cell_value,
  input  logic [5:0]         column,
  input  logic [13:0]        pos_x,
  input  logic [13:0]        pos_y,
  input  logic signed [10:0] dir_x,
  input  logic signed [10:0] dir_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         column_tag,
  output logic [5:0]         hit_x,
  output logic [5:0]         hit_y,
  output logic [7:0]         hit_code,
  output logic [7:0]         wall_height
);

  localparam int AW = 2 * MAP_BITS;
  localparam int RW = MAP_BITS + 10;

  logic          accept, wr_req, cast_req, idle, clearing;
  logic          rd_en, h_start;
  logic [AW-1:0] rd_addr, mem_addr;
  logic [7:0]    rd_data, h_u;
  logic [RW-1:0] h_r;
  logic [13:0]   wx_ext, wy_ext;
  grcwh_pkg::height_rsp_t h_rsp;

  assign in_ready = idle && !clearing;
  assign accept   = in_valid && in_ready;
  assign wr_req   = accept && (command == grcwh_pkg::CMD_WRITE);
  assign cast_req = accept && (command == grcwh_pkg::CMD_CAST);

  // write coordinates taken modulo the map side
  assign wx_ext   = {8'd0, cell_x};
  assign wy_ext   = {8'd0, cell_y};
  assign mem_addr = wr_req ? {wy_ext[MAP_BITS-1:0], wx_ext[MAP_BITS-1:0]} : rd_addr;

  grcwh_map #(
    .MAP_BITS(MAP_BITS)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .en      (wr_req || rd_en),
    .we      (wr_req),
    .addr    (mem_addr),
    .wdata   (cell_value),
    .rd_data (rd_data),
    .clearing(clearing)
  );

  grcwh_height #(
    .FAR_LIMIT(FAR_LIMIT),
    .RW       (RW)
  ) u_height (
    .clk  (clk),
    .rst  (rst),
    .start(h_start),
    .u    (h_u),
    .r    (h_r),
    .rsp  (h_rsp)
  );

  grcwh_tracer #(
    .MAP_BITS(MAP_BITS),
    .RW      (RW)
  ) u_tracer (
    .clk        (clk),
    .rst        (rst),
    .start      (cast_req),
    .column     (column),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .idle       (idle),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .h_start    (h_start),
    .h_u        (h_u),
    .h_r        (h_r),
    .h_rsp      (h_rsp),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .column_tag (column_tag),
    .hit_x      (hit_x),
    .hit_y      (hit_y),
    .hit_code   (hit_code),
    .wall_height(wall_height)
  );

endmodule

// ===== hdl/grcwh_checker.sv =====
// Port-level checker for the ray caster, bound to the top level.
module grcwh_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               command,
  input logic [5:0]         cell_x,
  input logic [5:0]         cell_y,
  input logic [7:0]         cell_value,
  input logic [5:0]         column,
  input logic [13:0]        pos_x,
  input logic [13:0]        pos_y,
  input logic signed [10:0] dir_x,
  input logic signed [10:0] dir_y,
  input logic               out_valid,
  input logic               out_ready,
  input logic [5:0]         column_tag,
  input logic [5:0]         hit_x,
  input logic [5:0]         hit_y,
  input logic [7:0]         hit_code,
  input logic [7:0]         wall_height
);

  // reset starts the clearing sweep and empties the result register
  a_reset_quiet: assert property (@(posedge clk) rst |=> !in_ready && !out_valid)
    else $error("request taken or result shown right after reset");

  // no request yields its result in the cycle after it is taken
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !out_valid) |=> !out_valid)
    else $error("result appeared one cycle after a request");

  // a miss carries zero hit coordinates, code and height; a hit always has a nonzero code
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit_code == 8'd0) |-> (wall_height == 8'd0 && hit_x == 6'd0 && hit_y == 6'd0))
    else $error("miss result with nonzero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(column_tag) && $stable(hit_code)
                                   && $stable(wall_height)))
    else $error("stalled result changed");

endmodule

bind grid_ray_cast_wall_height grcwh_checker u_checker (.*);
